/* rtl/core/lkc_pkg.sv */
`default_nettype none

package lkc_pkg;

  // Field and port widths
  localparam int KEY_W  = 32;
  localparam int CAP_W  = 5;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Storage depth default
  localparam int DEFAULT_MAX_ENTRIES = 16;

  // Capacity register
  localparam logic [CAP_W-1:0] CAP_RESET    = 5'd16;
  localparam logic             REG_CAPACITY = 1'b0;

  // Request kinds
  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming request
    logic match;   // register the key compare vector
    logic commit;  // load the result register
    logic write;   // apply the recency and store update
  } lkc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_put;
  } lkc_status_t;

endpackage

`default_nettype wire

/* rtl/core/lkc_ctrl.sv */
`default_nettype none

module lkc_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output lkc_pkg::lkc_cmd_t    cmd,
  input  lkc_pkg::lkc_status_t status
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  // Result register can take a new result when empty or draining
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // Commands
  always_comb begin
    cmd        = '0;
    cmd.load   = (state == ST_IDLE) && s_tvalid;
    cmd.match  = (state == ST_MATCH);
    cmd.commit = (state == ST_UPDATE) && out_free;
    cmd.write  = (state == ST_UPDATE) && out_free && status.is_put;
  end

  // Sequence one request through match and update
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_MATCH;
      ST_MATCH:  state_next = ST_UPDATE;
      ST_UPDATE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid: set on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lkc_datapath.sv */
`default_nettype none

module lkc_datapath #(
  parameter int MAX_ENTRIES = lkc_pkg::DEFAULT_MAX_ENTRIES
) (
  input  wire                         clk,
  input  wire                         rst,
  input  lkc_pkg::lkc_cmd_t           cmd,
  output lkc_pkg::lkc_status_t        status,
  input  wire                         in_op,
  input  wire  [lkc_pkg::KEY_W-1:0]   in_key,
  input  wire  [lkc_pkg::CAP_W-1:0]   capacity,
  output logic                        out_hit,
  output logic [lkc_pkg::KEY_W-1:0]   out_key
);

  localparam int RW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > lkc_pkg::CAP_W) ? CW : lkc_pkg::CAP_W;
  localparam logic [EW-1:0] MAX_E = EW'(MAX_ENTRIES);

  logic [lkc_pkg::KEY_W-1:0] key_store [MAX_ENTRIES];
  logic [RW-1:0]             rank      [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]    valid;
  logic [MAX_ENTRIES-1:0]    hit_vec;
  logic                      op_q;
  logic [lkc_pkg::KEY_W-1:0] key_q;

  logic                      hit_any;
  logic [RW-1:0]             hit_rank;
  logic [EW-1:0]             cap_ext;
  logic [EW-1:0]             cap_eff;
  logic [EW-1:0]             cap_m1;
  logic [MAX_ENTRIES-1:0]    evict;
  logic [MAX_ENTRIES-1:0]    keep;
  logic [MAX_ENTRIES-1:0]    free_vec;
  logic [MAX_ENTRIES-1:0]    first_free;

  assign status.is_put = (op_q == lkc_pkg::OP_PUT);

  // Capture request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_op;
      key_q <= in_key;
    end
  end

  // Parallel key compare, registered
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        hit_vec[i] <= valid[i] && (key_store[i] == key_q);
      end
    end
  end

  // Rank of the hit entry
  always_comb begin
    hit_any  = |hit_vec;
    hit_rank = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_rank = hit_rank | (hit_vec[i] ? rank[i] : '0);
    end
  end

  // Clamp capacity into 1..MAX_ENTRIES
  always_comb begin
    cap_ext = EW'(capacity);
    if (cap_ext == '0) begin
      cap_eff = EW'(1);
    end else if (cap_ext > MAX_E) begin
      cap_eff = MAX_E;
    end else begin
      cap_eff = cap_ext;
    end
    cap_m1 = cap_eff - EW'(1);
  end

  // Evict entries at or past the last allowed rank, pick the lowest free slot
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      evict[i] = valid[i] && (EW'(rank[i]) >= cap_m1);
    end
    keep       = valid & ~evict;
    free_vec   = ~keep;
    first_free = free_vec & (~free_vec + MAX_ENTRIES'(1));
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.write && !hit_any) begin
      valid <= keep | first_free;
    end
  end

  // Ranks and key store
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (hit_any) begin
          if (hit_vec[i]) begin
            rank[i] <= '0;
          end else if (valid[i] && (rank[i] < hit_rank)) begin
            rank[i] <= rank[i] + RW'(1);
          end
        end else begin
          if (first_free[i]) begin
            rank[i]      <= '0;
            key_store[i] <= key_q;
          end else if (keep[i]) begin
            rank[i] <= rank[i] + RW'(1);
          end
        end
      end
    end
  end

  // Result register; a miss reports all ones
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit <= hit_any;
      out_key <= hit_any ? key_q : '1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lru_key_cache.sv */
// An accepted request goes through the key match state, then the update state, which
// loads the result. The next request waits for the registered parallel key match
// followed by the rank table update, one request in flight at a time.
// A waiting result does not block acceptance of the next request; that request holds
// in update until the result is taken. Reset (synchronous, active high) empties the set,
// clears result valid, and sets capacity to 16.
`default_nettype none

module lru_key_cache #(
  parameter int MAX_ENTRIES = lkc_pkg::DEFAULT_MAX_ENTRIES
) (
  input  wire                          clk,
  input  wire                          rst,
  // request stream
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [lkc_pkg::KEY_W-1:0]    s_tdata,   // [31:0] key
  input  wire                          s_tuser,   // [0] opcode
  // result stream
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [lkc_pkg::KEY_W-1:0]    m_tdata,   // [31:0] key_out
  output logic                         m_tuser,   // [0] hit
  // configuration port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [lkc_pkg::ADDR_W-1:0]   paddr,
  input  wire  [lkc_pkg::DATA_W-1:0]   pwdata,
  output logic [lkc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  lkc_pkg::lkc_cmd_t         cmd;
  lkc_pkg::lkc_status_t      status;
  logic [lkc_pkg::CAP_W-1:0] capacity;

  assign pready = 1'b1;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkc_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == lkc_pkg::REG_CAPACITY)) begin
      capacity <= pwdata[lkc_pkg::CAP_W-1:0];
    end
  end

  // Register read
  always_comb begin
    prdata = '0;
    if (paddr[2] == lkc_pkg::REG_CAPACITY) begin
      prdata = lkc_pkg::DATA_W'(capacity);
    end
  end

  lkc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  lkc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_op    (s_tuser),
    .in_key   (s_tdata),
    .capacity (capacity),
    .out_hit  (m_tuser),
    .out_key  (m_tdata)
  );

endmodule

`default_nettype wire

/* rtl/core/lkc_checker.sv */
`default_nettype none

module lkc_checker (
  input wire                       clk,
  input wire                       rst,
  input wire                       s_tvalid,
  input wire                       s_tready,
  input wire                       m_tvalid,
  input wire                       m_tready,
  input wire [lkc_pkg::KEY_W-1:0]  m_tdata,
  input wire                       m_tuser
);

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // A miss reports all ones
  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '1)
    else $error("miss result not all ones");

  // One request at a time: no acceptance right after an acceptance
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in flight");

  // No result straight out of reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind lru_key_cache lkc_checker u_lkc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
